### sv/ctd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder package
// Shared types and constants for the front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ctd_pkg;

  localparam int unsigned CFG_W = 24;
  localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = 24'd10000000;

  // Wide enough for a held-line count at the largest line store size.
  localparam int unsigned LCNT_W = 9;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] ST_DECODE  = 2'd0;
  localparam logic [1:0] ST_TRAILER = 2'd1;
  localparam logic [1:0] ST_RAW     = 2'd2;

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_PRE,
    MODE_DIGITS,
    MODE_EXT,
    MODE_DROP,
    MODE_DATA,
    MODE_TRAILER,
    MODE_RAW
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_TAIL
  } bstate_t;

  typedef struct packed {
    logic              flush;
    logic [LCNT_W-1:0] flush_cnt;
    logic              tail;
    logic              tail_valid;
    logic [7:0]        tail_byte;
    logic [1:0]        tail_status;
    logic              last;
  } cmd_t;

endpackage

`default_nettype wire

### sv/ctd_if.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder channels
// Valid/ready channels for body bytes in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface chunk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface chunk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                input status, output ready);
endinterface

`default_nettype wire

### sv/ctd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/ctd_front.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder front end
// Parses size lines, tracks chunk data and issues output commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_front
  import ctd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned SIZE_BITS  = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  chunk_in_if.sink                           in_ch,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  output      logic                          push,
  output      cmd_t                          cmd,
  input  wire logic                          q_full,
  input  wire logic                          flush_done,
  output      logic                          wr_en,
  output      logic [$clog2(LINE_BYTES)-1:0] wr_addr,
  output      logic [7:0]                    wr_data
);

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned AW    = $clog2(LINE_BYTES);
  localparam int unsigned CMP_W = (SIZE_BITS + 4 > CFG_W) ? SIZE_BITS + 4 : CFG_W;
  localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(LINE_BYTES);
  localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C};
  endfunction

  mode_t                mode_r, mode_nxt, lm;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]           drop_r, drop_nxt, drop_dec;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]           prev1_r, prev1_nxt, prev2_r, prev2_nxt;
  logic [CFG_W-1:0]     max_r;
  logic                 blk_r, blk_nxt;
  logic                 accept;
  logic [7:0]           b;
  logic [4:0]           hx;
  logic [CMP_W-1:0]     val;
  logic                 over;
  logic                 x_prefix;
  logic                 raw_with_byte, raw_no_byte, line_flush;

  assign in_ch.ready = !q_full && !blk_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign hx          = hex_dec(b);
  assign lm          = (mode_r == MODE_SKIP) ? MODE_PRE : mode_r;
  assign val         = (lm == MODE_PRE) ? CMP_W'(hx[3:0]) : CMP_W'({acc_r, hx[3:0]});
  assign over        = (val > CMP_W'(max_r)) || (val > SIZE_CAP);
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign drop_dec    = drop_r - {1'b0, |drop_r};
  assign x_prefix    = (b == 8'h78 || b == 8'h58) && (acc_r == '0) && (cnt_r != '0)
                       && (prev1_r == 8'h30)
                       && ((cnt_r == CNT_W'(1)) || is_blank(prev2_r));
  assign wr_addr     = cnt_r[AW-1:0];
  assign wr_data     = b;

  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    drop_nxt      = drop_r;
    cnt_nxt       = cnt_r;
    prev1_nxt     = prev1_r;
    prev2_nxt     = prev2_r;
    cmd           = '0;
    wr_en         = 1'b0;
    raw_with_byte = 1'b0;
    raw_no_byte   = 1'b0;
    line_flush    = 1'b0;
    if (accept) begin
      case (mode_r)
        MODE_SKIP, MODE_PRE, MODE_DIGITS, MODE_EXT: begin
          if (!(mode_r == MODE_SKIP && (b == CH_CR || b == CH_LF))) begin
            mode_nxt = lm;
            if (b == CH_CR) begin
              if (lm == MODE_PRE) begin
                raw_with_byte = 1'b1;
              end else begin
                rem_nxt  = acc_r;
                drop_nxt = 2'd1;
                mode_nxt = MODE_DROP;
                cnt_nxt  = '0;
                acc_nxt  = '0;
              end
            end else if (cnt_r >= LINE_MAX) begin
              raw_with_byte = 1'b1;
            end else begin
              wr_en     = 1'b1;
              cnt_nxt   = cnt_inc;
              prev1_nxt = b;
              prev2_nxt = prev1_r;
              if (lm == MODE_PRE) begin
                if (!is_blank(b)) begin
                  if (!hx[4]) begin
                    raw_no_byte = 1'b1;
                  end else begin
                    acc_nxt  = val[SIZE_BITS-1:0];
                    mode_nxt = MODE_DIGITS;
                    raw_no_byte = over;
                  end
                end
              end else if (lm == MODE_DIGITS) begin
                if (hx[4]) begin
                  acc_nxt     = val[SIZE_BITS-1:0];
                  raw_no_byte = over;
                end else if (!x_prefix) begin
                  mode_nxt = MODE_EXT;
                end
              end
            end
          end
        end
        MODE_DROP: begin
          drop_nxt = drop_dec;
          if (drop_dec == 2'd0) begin
            mode_nxt = (rem_r != '0) ? MODE_DATA : MODE_TRAILER;
          end
        end
        MODE_DATA: begin
          if (rem_r != '0) begin
            cmd.tail        = 1'b1;
            cmd.tail_valid  = 1'b1;
            cmd.tail_byte   = b;
            cmd.tail_status = ST_DECODE;
            rem_nxt         = rem_r - SIZE_BITS'(1);
            if (rem_r == SIZE_BITS'(1)) begin
              drop_nxt = 2'd2;
            end
          end else begin
            drop_nxt = drop_dec;
            if (drop_dec == 2'd0) begin
              mode_nxt = MODE_SKIP;
              rem_nxt  = '0;
              drop_nxt = '0;
              cnt_nxt  = '0;
              acc_nxt  = '0;
            end
          end
        end
        MODE_TRAILER: begin
          cmd.tail        = 1'b1;
          cmd.tail_valid  = 1'b1;
          cmd.tail_byte   = b;
          cmd.tail_status = ST_TRAILER;
        end
        default: begin
          cmd.tail        = 1'b1;
          cmd.tail_valid  = 1'b1;
          cmd.tail_byte   = b;
          cmd.tail_status = ST_RAW;
        end
      endcase

      if (raw_with_byte || raw_no_byte) begin
        cmd.flush       = 1'b1;
        cmd.flush_cnt   = raw_with_byte ? LCNT_W'(cnt_r) : LCNT_W'(cnt_inc);
        cmd.tail        = raw_with_byte;
        cmd.tail_valid  = 1'b1;
        cmd.tail_byte   = b;
        cmd.tail_status = ST_RAW;
        mode_nxt        = MODE_RAW;
        cnt_nxt         = '0;
        acc_nxt         = '0;
      end

      if (in_ch.in_last) begin
        if (mode_nxt == MODE_PRE || mode_nxt == MODE_DIGITS || mode_nxt == MODE_EXT) begin
          line_flush    = 1'b1;
          cmd.flush     = 1'b1;
          cmd.flush_cnt = LCNT_W'(cnt_nxt);
        end
        if (!(cmd.tail || (cmd.flush && cmd.flush_cnt != '0))) begin
          cmd.tail        = 1'b1;
          cmd.tail_valid  = 1'b0;
          cmd.tail_byte   = 8'h00;
          cmd.tail_status = (mode_nxt == MODE_TRAILER) ? ST_TRAILER
                          : ((mode_nxt == MODE_RAW || line_flush) ? ST_RAW : ST_DECODE);
        end
        cmd.last = 1'b1;
        mode_nxt = MODE_SKIP;
        rem_nxt  = '0;
        drop_nxt = '0;
        cnt_nxt  = '0;
        acc_nxt  = '0;
      end
    end
  end

  assign push    = cmd.flush || cmd.tail;
  assign blk_nxt = (push && cmd.flush) ? 1'b1 : (flush_done ? 1'b0 : blk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      acc_r  <= '0;
      rem_r  <= '0;
      drop_r <= '0;
      cnt_r  <= '0;
      blk_r  <= 1'b0;
      max_r  <= MAX_CHUNK_RESET;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      drop_r <= drop_nxt;
      cnt_r  <= cnt_nxt;
      blk_r  <= blk_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev1_r <= prev1_nxt;
    prev2_r <= prev2_nxt;
  end

endmodule

`default_nettype wire

### sv/ctd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder command queue
// Two-entry queue of output commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_cmd_fifo
  import ctd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t head,
  output      logic head_vld
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### sv/ctd_back.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder back end
// Carries out queued commands: replays held lines and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_back
  import ctd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cmd_t                          head,
  input  wire logic                          head_vld,
  output      logic                          pop,
  output      logic                          flush_done,
  output      logic                          rd_en,
  output      logic [$clog2(LINE_BYTES)-1:0] rd_addr,
  input  wire logic [7:0]                    rd_data,
  chunk_out_if.source                        out_ch
);

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned AW    = $clog2(LINE_BYTES);

  bstate_t          st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, idx_inc;
  logic             last_idx;
  logic             load_ok, load;
  logic [7:0]       ld_byte;
  logic             ld_valid, ld_last;
  logic [1:0]       ld_st;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ovl_r, olast_r;
  logic [1:0]       ost_r;

  assign idx_inc  = idx_r + CNT_W'(1);
  assign last_idx = (LCNT_W'(idx_inc) == head.flush_cnt);
  assign load_ok  = !ov_r || out_ch.ready;
  assign rd_addr  = idx_r[AW-1:0];

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    pop        = 1'b0;
    flush_done = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    ld_byte    = head.tail_byte;
    ld_valid   = head.tail_valid;
    ld_last    = head.last;
    ld_st      = head.tail_status;
    case (st_r)
      BK_IDLE: begin
        if (head_vld) begin
          if (head.flush) begin
            if (head.flush_cnt != '0) begin
              idx_nxt = '0;
              st_nxt  = BK_READ;
            end else begin
              flush_done = 1'b1;
              st_nxt     = BK_TAIL;
            end
          end else if (load_ok) begin
            load = 1'b1;
            pop  = 1'b1;
          end
        end
      end
      BK_READ: begin
        rd_en  = 1'b1;
        st_nxt = BK_WAIT;
      end
      BK_WAIT: begin
        if (load_ok) begin
          load     = 1'b1;
          ld_byte  = rd_data;
          ld_valid = 1'b1;
          ld_st    = ST_RAW;
          ld_last  = head.last && !head.tail && last_idx;
          idx_nxt  = idx_inc;
          if (last_idx) begin
            flush_done = 1'b1;
            st_nxt     = BK_TAIL;
          end else begin
            st_nxt = BK_READ;
          end
        end
      end
      BK_TAIL: begin
        if (!head.tail) begin
          pop    = 1'b1;
          st_nxt = BK_IDLE;
        end else if (load_ok) begin
          load   = 1'b1;
          pop    = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r    <= ld_byte;
      ovl_r   <= ld_valid;
      olast_r <= ld_last;
      ost_r   <= ld_st;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = ob_r;
  assign out_ch.out_valid = ovl_r;
  assign out_ch.out_last  = olast_r;
  assign out_ch.status    = ost_r;

endmodule

`default_nettype wire

### sv/chunked_transfer_decoder_core.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder
// Strips chunked framing from a byte stream, falling back to raw passthrough.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                   Handshake
//  in_ch    in         in_byte[7:0], in_last                     valid/ready
//  out_ch   out        out_byte[7:0], out_valid, out_last,       valid/ready
//                      status[1:0]
//  cfg      in         cfg_wdata[23:0] (largest chunk size)      cfg_we strobe
//
//  Data and passthrough bytes stream at one per cycle unless the output stalls or
//  a held size line is replayed. Replay uses a read and a wait state per held
//  byte, reading the line store one entry at a time; input is held off meanwhile.
//  Reset is synchronous; the line store is not cleared and needs no sweep.
//  A stalled result register back-pressures the two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_transfer_decoder_core
  import ctd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned SIZE_BITS  = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  chunk_in_if.sink              in_ch,
  chunk_out_if.source           out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(LINE_BYTES);

  logic          push, q_full, pop, head_vld, flush_done;
  cmd_t          push_cmd, head;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  ctd_front #(
    .LINE_BYTES (LINE_BYTES),
    .SIZE_BITS  (SIZE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .cmd        (push_cmd),
    .q_full     (q_full),
    .flush_done (flush_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ctd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .head_vld (head_vld)
  );

  ctd_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ctd_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_vld   (head_vld),
    .pop        (pop),
    .flush_done (flush_done),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### sv/ctd_checker.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_port_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_vld,
  input wire logic       out_rdy,
  input wire logic [7:0] out_byte,
  input wire logic       out_valid,
  input wire logic       out_last,
  input wire logic [1:0] status
);

  // A stalled request keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(out_valid)
                            && $stable(out_last) && $stable(status))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_vld)
    else $error("result presented straight after reset");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> out_last)
    else $error("bare end marker without last");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> out_byte == 8'h00)
    else $error("bare end marker carries a byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind chunked_transfer_decoder_core ctd_port_checker u_ctd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_vld   (out_ch.valid),
  .out_rdy   (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_valid (out_ch.out_valid),
  .out_last  (out_ch.out_last),
  .status    (out_ch.status)
);

`default_nettype wire

### dv/ctd_checker.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder checker
// Watches both channels and the limit register, keeps its own decoder state to
// predict the results of every accepted request, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ctd_checker
  import ctd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  chunk_in_if                   mon_in,
  chunk_out_if                  mon_out,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    logic [1:0] status;
  } result_t;

  result_t          out_bytes_due[$];
  logic [CFG_W-1:0] size_limit;
  mode_t            mode;
  logic [31:0]      size_acc;
  logic [31:0]      data_left;
  int               drop_left;
  logic [7:0]       line_buf [LINE_BYTES];
  int               line_len;
  logic             digit_seen;

  function automatic bit is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == CH_LF || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic int hex_val(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  task automatic clear_line();
    line_len   = 0;
    digit_seen = 1'b0;
    size_acc   = '0;
  endtask

  task automatic restart_parse();
    mode      = MODE_SKIP;
    data_left = '0;
    drop_left = 0;
    clear_line();
  endtask

  task automatic push_result(input logic [7:0] b, input logic dv, input logic [1:0] st,
                             inout int n);
    result_t r;
    r.data       = b;
    r.data_valid = dv;
    r.last       = 1'b0;
    r.status     = st;
    out_bytes_due.push_back(r);
    n++;
  endtask

  task automatic flush_held(inout int n);
    for (int i = 0; i < line_len; i++) begin
      push_result(line_buf[i], 1'b1, ST_RAW, n);
    end
    clear_line();
    mode = MODE_RAW;
  endtask

  task automatic take_line_byte(input logic [7:0] b, inout int n);
    int d;
    bit prefix;
    if (b == CH_CR) begin
      if (mode == MODE_PRE || !digit_seen) begin
        flush_held(n);
        push_result(b, 1'b1, ST_RAW, n);
      end else begin
        data_left = size_acc;
        drop_left = 1;
        mode      = MODE_DROP;
        clear_line();
      end
    end else if (line_len >= LINE_BYTES) begin
      flush_held(n);
      push_result(b, 1'b1, ST_RAW, n);
    end else begin
      line_buf[line_len] = b;
      line_len++;
      d = hex_val(b);
      if (mode == MODE_PRE) begin
        if (!is_blank(b)) begin
          if (d < 0) begin
            flush_held(n);
          end else begin
            digit_seen = 1'b1;
            size_acc   = d;
            mode       = MODE_DIGITS;
            if (size_acc > size_limit) flush_held(n);
          end
        end
      end else if (mode == MODE_DIGITS) begin
        if (d >= 0) begin
          size_acc = size_acc * 16 + d;
          if (size_acc > size_limit) flush_held(n);
        end else begin
          prefix = (b == "x" || b == "X") && size_acc == 0 && line_len >= 2 &&
                   line_buf[line_len-2] == "0" &&
                   (line_len == 2 || is_blank(line_buf[line_len-3]));
          if (!prefix) mode = MODE_EXT;
        end
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int n;
    result_t r;
    logic [1:0] st;
    n = 0;
    case (mode)
      MODE_SKIP: begin
        if (b != CH_CR && b != CH_LF) begin
          mode = MODE_PRE;
          take_line_byte(b, n);
        end
      end
      MODE_PRE, MODE_DIGITS, MODE_EXT: begin
        take_line_byte(b, n);
      end
      MODE_DROP: begin
        if (drop_left > 0) drop_left--;
        if (drop_left == 0) mode = (data_left != 0) ? MODE_DATA : MODE_TRAILER;
      end
      MODE_DATA: begin
        if (data_left > 0) begin
          push_result(b, 1'b1, ST_DECODE, n);
          data_left--;
          if (data_left == 0) drop_left = 2;
        end else begin
          if (drop_left > 0) drop_left--;
          if (drop_left == 0) restart_parse();
        end
      end
      MODE_TRAILER: begin
        push_result(b, 1'b1, ST_TRAILER, n);
      end
      default: begin
        push_result(b, 1'b1, ST_RAW, n);
      end
    endcase
    if (last) begin
      if (mode == MODE_PRE || mode == MODE_DIGITS || mode == MODE_EXT) flush_held(n);
      if (n == 0) begin
        st = (mode == MODE_TRAILER) ? ST_TRAILER : (mode == MODE_RAW) ? ST_RAW : ST_DECODE;
        push_result(8'h00, 1'b0, st, n);
      end
      r = out_bytes_due.pop_back();
      r.last = 1'b1;
      out_bytes_due.push_back(r);
      restart_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      errors     = 0;
      size_limit = MAX_CHUNK_RESET;
      out_bytes_due.delete();
      restart_parse();
    end else begin
      if (cfg_we) size_limit = cfg_wdata;
      if (mon_in.valid && mon_in.ready) decode_byte(mon_in.in_byte, mon_in.in_last);
      if (mon_out.valid && mon_out.ready) begin
        if (out_bytes_due.size() == 0) begin
          $error("out_byte: result %0h arrived with nothing predicted", mon_out.out_byte);
          errors++;
        end else begin
          want = out_bytes_due.pop_front();
          check_field("out_byte", want.data, mon_out.out_byte);
          check_field("out_valid", 8'(want.data_valid), 8'(mon_out.out_valid));
          check_field("out_last", 8'(want.last), 8'(mon_out.out_last));
          check_field("status", 8'(want.status), 8'(mon_out.status));
        end
      end
    end
    pending = out_bytes_due.size();
  end

endmodule

### dv/tb_chunked_transfer_decoder_core.sv
// ----------------------------------------------------------------------------
// Chunked transfer decoder testbench
// Sends short directed bodies and then mostly well-formed random chunked
// bodies, mixed with noise and cut-off streams, under four idling phases and
// several chunk size limits. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_chunked_transfer_decoder_core;
  import ctd_pkg::*;

  localparam int unsigned LINE_BYTES   = 32;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 2 * LINE_BYTES + 40;
  localparam int          PHASE_ITEMS  = 48;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             src_valid  = 1'b0;
  logic [7:0]       src_byte   = 8'h00;
  logic             src_last   = 1'b0;
  logic             sink_ready = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [CFG_W-1:0] cfg_wdata  = '0;

  int         src_idle_pct   = 0;
  int         sink_stall_pct = 0;
  int         cycles         = 0;
  int         sent;
  int         errors;
  int         pending;
  logic [7:0] body_q[$];

  chunk_in_if  in_ch ();
  chunk_out_if out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.in_byte = src_byte;
  assign in_ch.in_last = src_last;
  assign out_ch.ready  = sink_ready;

  chunked_transfer_decoder_core #(
    .LINE_BYTES(LINE_BYTES),
    .SIZE_BITS (24)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  ctd_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .mon_in   (in_ch),
    .mon_out  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    sink_ready <= (sink_stall_pct == 0) || ($urandom_range(99, 0) >= sink_stall_pct);
  end

  task automatic send_req(input logic [7:0] b, input logic l);
    while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    src_last  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_body();
    foreach (body_q[i]) send_req(body_q[i], i == body_q.size() - 1);
    body_q.delete();
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic push_blank();
    logic [7:0] blanks [5];
    blanks = '{8'h20, 8'h09, CH_LF, 8'h0B, 8'h0C};
    body_q.push_back(blanks[$urandom_range(4, 0)]);
  endtask

  task automatic push_hex(input logic [31:0] v, input int min_digits, input bit upper);
    logic [3:0] nib[$];
    logic [3:0] x;
    do begin
      nib.push_front(v[3:0]);
      v = v >> 4;
    end while (v != 0);
    while (nib.size() < min_digits) nib.push_front(4'h0);
    foreach (nib[i]) begin
      x = nib[i];
      body_q.push_back(x < 10 ? 8'h30 + 8'(x) : (upper ? 8'h41 : 8'h61) + 8'(x) - 8'd10);
    end
  endtask

  task automatic push_size_line(input logic [31:0] sz);
    int         pad;
    int         ext;
    logic [7:0] b;
    pad = 1;
    if ($urandom_range(3, 0) == 0) begin
      repeat ($urandom_range(2, 1)) push_blank();
    end
    if ($urandom_range(5, 0) == 0) begin
      body_q.push_back("0");
      body_q.push_back($urandom_range(1, 0) ? "x" : "X");
    end else if ($urandom_range(5, 0) == 0) begin
      pad = $urandom_range(4, 2) + (sz > 15);
    end
    push_hex(sz, pad, $urandom_range(1, 0));
    ext = $urandom_range(9, 0);
    if (ext < 4) begin
      body_q.push_back(";");
      repeat (ext == 3 ? $urandom_range(36, 26) : $urandom_range(4, 0)) begin
        b = 8'($urandom);
        body_q.push_back(b == CH_CR ? 8'h3B : b);
      end
    end
    body_q.push_back(CH_CR);
    body_q.push_back($urandom_range(7, 0) == 0 ? 8'($urandom) : CH_LF);
  endtask

  task automatic make_random_body();
    int          kind;
    int          cut;
    logic [31:0] sz;
    kind = $urandom_range(9, 0);
    if (kind >= 8) begin
      repeat ($urandom_range(12, 1)) body_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(2, 0)) body_q.push_back($urandom_range(1, 0) ? CH_CR : CH_LF);
      if (kind == 7) begin
        push_size_line($urandom & 32'h0FFF_FFFF);
        repeat ($urandom_range(6, 1)) body_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          sz = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
          push_size_line(sz);
          repeat (sz) body_q.push_back(8'($urandom));
          if ($urandom_range(7, 0) == 0) begin
            repeat (2) body_q.push_back(8'($urandom));
          end else begin
            body_q.push_back(CH_CR);
            body_q.push_back(CH_LF);
          end
        end
        if ($urandom_range(1, 0) == 1) begin
          push_size_line(0);
          repeat ($urandom_range(5, 0)) body_q.push_back(8'($urandom));
        end
      end
      if ($urandom_range(3, 0) == 0 && body_q.size() > 1) begin
        cut = $urandom_range(body_q.size() - 1, 1);
        while (body_q.size() > cut) void'(body_q.pop_back());
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Skipped breaks, data bytes at both extremes, zero chunk and trailer.
    push_text("\n\r2\r\n");
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    push_text("\r\n0\r\nZ");
    send_body();
    // Blanks, hex prefix and an extension, then the stream ends inside data.
    push_text(" 0x1;q\r\nA");
    send_body();
    // A line with no digits at all.
    push_text("g");
    send_body();
    // A lone line break that yields only a bare end marker.
    push_text("\r");
    send_body();
    // One past the reset limit.
    push_text("989681");
    send_body();
    // Stream ends while a size line is still held.
    push_text("1F");
    send_body();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: write_limit(24'hFF_FFFF);
        2: write_limit(24'h00_0000);
        3: write_limit(CFG_W'($urandom_range(40, 1)));
        default: ;
      endcase
      src_idle_pct   = (phase == 1) ? 56 : (phase == 3) ? 31 : 0;
      sink_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 31 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_random_body();
        send_body();
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
